/* hdl/phone_digit_match_key_top_assert.svh */
// assertion macros shared by the match key modules
// expects clk_i and rst_ni in the module that uses them
`ifndef PHONE_DIGIT_MATCH_KEY_TOP_ASSERT_SVH
`define PHONE_DIGIT_MATCH_KEY_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define PDMK_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define PDMK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pdmk_pkg.sv */
// types and constants of the phone digit match key block
// no dependencies
package pdmk_pkg;

  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned CHAR_W      = 16;
  localparam int unsigned MATCH_W     = 4;
  localparam int unsigned LOWER_KEY_W = 24;
  localparam int unsigned UPPER_KEY_W = 27;
  localparam int unsigned LOWER_CNT_W = 3;
  localparam int unsigned UPPER_CNT_W = 4;
  localparam int unsigned M_TDATA_W   = 64;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 16'h0030;
  localparam logic [CHAR_W-1:0]  CHAR_NINE   = 16'h0039;
  localparam logic [MATCH_W-1:0] MATCH_RESET = 4'd7;

  // register index, taken from paddr[2]
  localparam logic REG_MATCH_DIGITS = 1'b0;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic [LOWER_KEY_W-1:0] lower_key;
    logic [UPPER_KEY_W-1:0] upper_key;
    logic [LOWER_CNT_W-1:0] lower_count;
    logic [UPPER_CNT_W-1:0] upper_count;
    logic                   no_digits;
  } pdmk_res_t;

endpackage

/* hdl/pdmk_key_cell.sv */
// one stage of the key chain: folds one lower and one upper digit into the keys
// depends on pdmk_pkg
module pdmk_key_cell import pdmk_pkg::*; #(
  parameter int unsigned NUM_STAGES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  pdmk_res_t                  res_i,
  input  digit_t [NUM_STAGES-1:0]    lo_i,
  input  digit_t [NUM_STAGES-1:0]    up_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output pdmk_res_t                  res_o,
  output digit_t [NUM_STAGES-1:0]    lo_o,
  output digit_t [NUM_STAGES-1:0]    up_o
);

  logic                    valid_q, valid_d;
  pdmk_res_t               res_q, res_d;
  digit_t [NUM_STAGES-1:0] lo_q, lo_d, up_q, up_d;
  logic [LOWER_KEY_W-1:0]  lk;
  logic [UPPER_KEY_W-1:0]  uk;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  // key = key * 10 + digit, digit at the bottom of each sequence
  always_comb begin
    lk    = res_i.lower_key;
    uk    = res_i.upper_key;
    res_d = res_i;
    res_d.lower_key = {lk[LOWER_KEY_W-4:0], 3'b000} + {lk[LOWER_KEY_W-2:0], 1'b0}
                      + LOWER_KEY_W'(lo_i[0]);
    res_d.upper_key = {uk[UPPER_KEY_W-4:0], 3'b000} + {uk[UPPER_KEY_W-2:0], 1'b0}
                      + UPPER_KEY_W'(up_i[0]);
    lo_d = lo_i >> DIGIT_W;
    up_d = up_i >> DIGIT_W;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
      lo_q  <= lo_d;
      up_q  <= up_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign lo_o    = lo_q;
  assign up_o    = up_q;

endmodule

/* hdl/pdmk_digit_row.sv */
// digit history row and digit count, plus the masked digit sequences for the key chain
// depends on pdmk_pkg and the assertion macro header
`include "phone_digit_match_key_top_assert.svh"
module pdmk_digit_row import pdmk_pkg::*; #(
  parameter int unsigned LOWER_DIGITS = 7,
  parameter int unsigned TOTAL_DIGITS = 15,
  parameter int unsigned UPPER_SLOTS  = 8,
  parameter int unsigned NUM_STAGES   = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [CHAR_W-1:0]       char_code_i,
  input  logic                    last_i,
  input  logic [MATCH_W-1:0]      match_digits_i,
  output pdmk_res_t               res_o,
  output digit_t [NUM_STAGES-1:0] lo_seq_o,
  output digit_t [NUM_STAGES-1:0] up_seq_o
);

  localparam int unsigned CW = $clog2(TOTAL_DIGITS + 1);
  localparam int unsigned AW = (CW > MATCH_W) ? CW : MATCH_W;
  localparam int unsigned UPPER_SPAN =
    (TOTAL_DIGITS > LOWER_DIGITS) ? TOTAL_DIGITS - LOWER_DIGITS : 0;
  localparam int unsigned LO_OFS = NUM_STAGES - LOWER_DIGITS;
  localparam int unsigned UP_OFS = NUM_STAGES - UPPER_SLOTS;

  digit_t [TOTAL_DIGITS-1:0] hist_q, hist_d, hist_nx;
  logic [CW-1:0]             count_q, count_d, count_nx;
  logic                      is_digit;
  logic [AW-1:0]             m, nlow, nup, n, lc, uc, low_a, tot_a;

  assign is_digit = char_code_i inside {[CHAR_ZERO:CHAR_NINE]};

  always_comb begin
    hist_nx  = hist_q;
    count_nx = count_q;
    if (is_digit) begin
      hist_nx = {hist_q[TOTAL_DIGITS-2:0], char_code_i[DIGIT_W-1:0]};
      if (count_q != CW'(TOTAL_DIGITS)) begin
        count_nx = count_q + CW'(1);
      end
    end
    hist_d  = accept_i ? hist_nx : hist_q;
    count_d = count_q;
    if (accept_i) begin
      count_d = last_i ? '0 : count_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      count_q <= '0;
    end else begin
      hist_q  <= hist_d;
      count_q <= count_d;
    end
  end

  // digit counts used by the keys of a number ending with this character
  always_comb begin
    low_a = AW'(LOWER_DIGITS);
    tot_a = AW'(TOTAL_DIGITS);
    m     = AW'(match_digits_i);
    if (m > tot_a) begin
      m = tot_a;
    end
    nlow = m;
    nup  = '0;
    if (m > low_a) begin
      nlow = low_a;
      nup  = m - low_a;
    end else if (m == '0) begin
      nlow = low_a;
    end
    n  = AW'(count_nx);
    lc = (n < nlow) ? n : nlow;
    uc = '0;
    if (n > low_a && nup != '0) begin
      uc = ((n - low_a) > nup) ? nup : (n - low_a);
    end
  end

  always_comb begin
    res_o             = '0;
    res_o.lower_count = LOWER_CNT_W'(lc);
    res_o.upper_count = UPPER_CNT_W'(uc);
    res_o.no_digits   = (n == '0);
  end

  // sequences are right aligned so every stage multiplies by ten
  for (genvar j = 0; j < NUM_STAGES; j++) begin : g_seq
    if (j < LO_OFS || (j - LO_OFS) >= TOTAL_DIGITS) begin : g_lo_zero
      assign lo_seq_o[j] = '0;
    end else begin : g_lo
      assign lo_seq_o[j] = (AW'(j - LO_OFS) < lc) ? hist_nx[j - LO_OFS] : '0;
    end
    if (j < UP_OFS || UPPER_SPAN == 0 ||
        (LOWER_DIGITS + j - UP_OFS) >= TOTAL_DIGITS) begin : g_up_zero
      assign up_seq_o[j] = '0;
    end else begin : g_up
      assign up_seq_o[j] = (AW'(j - UP_OFS) < uc) ? hist_nx[LOWER_DIGITS + j - UP_OFS] : '0;
    end
  end

  `PDMK_ASSERT_NEXT(a_last_clears_count, accept_i && last_i, count_q == '0,
                    "digit count not cleared after last character")
  `PDMK_ASSERT_HOLDS(a_count_saturates, 1'b1, count_q <= CW'(TOTAL_DIGITS),
                     "digit count above history depth")

endmodule

/* hdl/phone_digit_match_key_top.sv */
// a result passes through the registered key chain once its last character is taken,
// one stage of the key chain per digit position; the last stage is the output register.
// throughput: one character per cycle while the output does not stall the chain;
// the key chain holds one number per stage. reset: asynchronous, active low; clears
// the digit count, history, chain valid bits and sets match_digits to 7.
// depends on pdmk_pkg, pdmk_digit_row, pdmk_key_cell and the assertion macro header
`include "phone_digit_match_key_top_assert.svh"
module phone_digit_match_key_top import pdmk_pkg::*; #(
  parameter int unsigned LOWER_DIGITS = 7,
  parameter int unsigned TOTAL_DIGITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [CHAR_W-1:0]     s_axis_tdata_i,    // [15:0] char_code
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [23:0] lower_key, [50:24] upper_key, [53:51] lower_count, [57:54] upper_count
  output logic [M_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                  m_axis_tuser_o,    // [0] no_digits
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned UPPER_SPAN =
    (TOTAL_DIGITS > LOWER_DIGITS) ? TOTAL_DIGITS - LOWER_DIGITS : 0;
  localparam int unsigned UPPER_SLOTS = (UPPER_SPAN > 0) ? UPPER_SPAN : 1;
  localparam int unsigned NUM_STAGES  =
    (LOWER_DIGITS > UPPER_SLOTS) ? LOWER_DIGITS : UPPER_SLOTS;

  logic [MATCH_W-1:0] match_q, match_d;
  logic               reg_hit;
  logic               in_accept;

  logic [NUM_STAGES:0]                        st_valid, st_ready;
  pdmk_res_t                                  st_res [NUM_STAGES+1];
  logic [NUM_STAGES:0][NUM_STAGES-1:0][DIGIT_W-1:0] st_lo, st_up;
  pdmk_res_t                                  out_res;

  // configuration port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1] == REG_MATCH_DIGITS);
  assign match_d = (psel && penable && pwrite && reg_hit) ? pwdata[MATCH_W-1:0] : match_q;
  assign prdata  = reg_hit ? APB_DATA_W'(match_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= MATCH_RESET;
    end else begin
      match_q <= match_d;
    end
  end

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = st_ready[0];
  assign st_valid[0]     = s_axis_tvalid_i && s_axis_tlast_i;

  pdmk_digit_row #(
    .LOWER_DIGITS (LOWER_DIGITS),
    .TOTAL_DIGITS (TOTAL_DIGITS),
    .UPPER_SLOTS  (UPPER_SLOTS),
    .NUM_STAGES   (NUM_STAGES)
  ) u_row (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .char_code_i    (s_axis_tdata_i),
    .last_i         (s_axis_tlast_i),
    .match_digits_i (match_q),
    .res_o          (st_res[0]),
    .lo_seq_o       (st_lo[0]),
    .up_seq_o       (st_up[0])
  );

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
    pdmk_key_cell #(
      .NUM_STAGES (NUM_STAGES)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[k]),
      .ready_o (st_ready[k]),
      .res_i   (st_res[k]),
      .lo_i    (st_lo[k]),
      .up_i    (st_up[k]),
      .valid_o (st_valid[k+1]),
      .ready_i (st_ready[k+1]),
      .res_o   (st_res[k+1]),
      .lo_o    (st_lo[k+1]),
      .up_o    (st_up[k+1])
    );
  end

  // last stage is the output register
  assign st_ready[NUM_STAGES] = m_axis_tready_i;
  assign out_res              = st_res[NUM_STAGES];
  assign m_axis_tvalid_o      = st_valid[NUM_STAGES];
  assign m_axis_tdata_o       = M_TDATA_W'({out_res.upper_count, out_res.lower_count,
                                            out_res.upper_key, out_res.lower_key});
  assign m_axis_tuser_o       = out_res.no_digits;

  `PDMK_ASSERT_HOLDS(a_empty_number_zero, m_axis_tvalid_o && m_axis_tuser_o,
                     m_axis_tdata_o == '0, "number without digits gave nonzero keys")
  `PDMK_ASSERT_HOLDS(a_upper_needs_full_lower,
                     m_axis_tvalid_o && out_res.upper_count != '0,
                     out_res.lower_count == LOWER_CNT_W'(LOWER_DIGITS),
                     "upper digits used with a short lower key")

endmodule
